### rtl/core/crc_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkg
// Shared constants, item and result types for the centroid radius crop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crc_pkg;

	localparam int MAX_PROTEIN_ATOMS = 4096;
	localparam int MAX_LIGAND_ATOMS  = 1024;

	localparam int COORD_W  = 24;
	localparam int BOND_W   = 13;
	localparam int INDEX_W  = 12;
	localparam int ORDER_W  = 4;
	localparam int ANUM_W   = 7;
	localparam int RADIUS_W = 16;

	localparam int PROT_AW  = $clog2(MAX_PROTEIN_ATOMS);
	localparam int SEEN_W   = PROT_AW + 1;
	localparam int HEAVY_W  = $clog2(MAX_LIGAND_ATOMS) + 1;
	localparam int SUM_W    = COORD_W + $clog2(MAX_LIGAND_ATOMS);
	localparam int DIV_W    = SUM_W + 2;
	localparam int DVSR_W   = HEAVY_W + 1;
	localparam int REM_W    = DVSR_W + 1;
	localparam int DIVCNT_W = $clog2(DIV_W + 1);
	localparam int SQ_W     = 2 * COORD_W;
	localparam int D2_W     = SQ_W + 2;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int MAP_W    = INDEX_W + 1;
	localparam int AXES     = 3;
	localparam int AXIS_W   = $clog2(AXES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic KIND_ATOM = 1'b0;
	localparam logic KIND_BOND = 1'b1;

	typedef enum logic [1:0] {
		CMD_LIGAND  = 2'd0,
		CMD_PROTEIN = 2'd1,
		CMD_BOND    = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                      kind;
		logic                      heavy;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [BOND_W-1:0]         first;
		logic [BOND_W-1:0]         second;
		logic [ORDER_W-1:0]        order;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic               kept;
		logic [INDEX_W-1:0] new_first;
		logic [INDEX_W-1:0] new_second;
		logic [ORDER_W-1:0] order;
		logic               overflow;
	} result_t;

	// Hydrogen by flag, by atomic number one, or by name when the number is unknown
	function automatic logic heavy_atom(input logic hf, input logic [ANUM_W-1:0] an,
			input logic eh);
		logic h;
		h = hf || (an == ANUM_W'(1)) || ((an == '0) && eh);
		return !h;
	endfunction

endpackage

`default_nettype wire

### rtl/core/centroid_radius_crop.sv
// ----------------------------------------------------------------------------
// centroid_radius_crop
// Crops protein atoms and bonds to a sphere around a ligand's heavy-atom center.
// ----------------------------------------------------------------------------
// Usage:
//   Present a request on the field ports with start high; it is taken at a
//   rising edge where busy is low. cmd selects ligand atom, protein atom, bond
//   or clear. busy rises when the two-entry request queue is full.
//   Protein atoms and bonds each produce one result, shown for one cycle with
//   done high; the receiver cannot stall, and done falls after that cycle.
//   Ligand atoms and clear produce no result.
//   Execution: a ligand atom or clear is handled in the idle state, a protein atom
//   takes three squared-distance steps through one 24x24 multiplier, and a bond
//   waits on a registered index-map read. The first protein atom of a job, when heavy
//   atoms were summed, first runs the bit-serial rounding divide of the three center sums.
//   Write crop_radius through cfg_we/cfg_data only while idle; the block does not enforce it.
//   Reset clears all job state and sets the radius to 10.0 angstrom; the
//   index map needs no clearing, since only entries below the seen count are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module centroid_radius_crop (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic                               cfg_we,
	input  wire logic [crc_pkg::RADIUS_W-1:0]       cfg_data,
	input  wire logic [1:0]                         cmd,
	input  wire logic signed [crc_pkg::COORD_W-1:0] x_coord,
	input  wire logic signed [crc_pkg::COORD_W-1:0] y_coord,
	input  wire logic signed [crc_pkg::COORD_W-1:0] z_coord,
	input  wire logic                               hydrogen_flag,
	input  wire logic [crc_pkg::ANUM_W-1:0]         atomic_number,
	input  wire logic                               element_hydrogen,
	input  wire logic signed [crc_pkg::BOND_W-1:0]  first_atom,
	input  wire logic signed [crc_pkg::BOND_W-1:0]  second_atom,
	input  wire logic [crc_pkg::ORDER_W-1:0]        bond_order,
	output logic                                    done,
	output logic                                    result_kind,
	output logic                                    kept,
	output logic [crc_pkg::INDEX_W-1:0]             new_first,
	output logic [crc_pkg::INDEX_W-1:0]             new_second,
	output logic [crc_pkg::ORDER_W-1:0]             order_out,
	output logic                                    overflow
);

	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	crc_pkg::item_t   push_item;
	crc_pkg::item_t   head;
	crc_pkg::result_t result;

	crc_front u_front (
		.start            (start),
		.full             (full),
		.cmd              (cmd),
		.x_coord          (x_coord),
		.y_coord          (y_coord),
		.z_coord          (z_coord),
		.hydrogen_flag    (hydrogen_flag),
		.atomic_number    (atomic_number),
		.element_hydrogen (element_hydrogen),
		.first_atom       (first_atom),
		.second_atom      (second_atom),
		.bond_order       (bond_order),
		.push             (push),
		.push_item        (push_item)
	);

	crc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	crc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);

	assign busy        = full;
	assign result_kind = result.kind;
	assign kept        = result.kept;
	assign new_first   = result.new_first;
	assign new_second  = result.new_second;
	assign order_out   = result.order;
	assign overflow    = result.overflow;

endmodule

`default_nettype wire

### rtl/core/crc_front.sv
// ----------------------------------------------------------------------------
// crc_front
// Accepts requests and classifies them into queue items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_front (
	input  wire logic                               start,
	input  wire logic                               full,
	input  wire logic [1:0]                         cmd,
	input  wire logic signed [crc_pkg::COORD_W-1:0] x_coord,
	input  wire logic signed [crc_pkg::COORD_W-1:0] y_coord,
	input  wire logic signed [crc_pkg::COORD_W-1:0] z_coord,
	input  wire logic                               hydrogen_flag,
	input  wire logic [crc_pkg::ANUM_W-1:0]         atomic_number,
	input  wire logic                               element_hydrogen,
	input  wire logic signed [crc_pkg::BOND_W-1:0]  first_atom,
	input  wire logic signed [crc_pkg::BOND_W-1:0]  second_atom,
	input  wire logic [crc_pkg::ORDER_W-1:0]        bond_order,
	output logic                                    push,
	output crc_pkg::item_t                          push_item
);

	assign push = start && !full;

	always_comb begin
		push_item.kind   = crc_pkg::cmd_t'(cmd);
		push_item.heavy  = crc_pkg::heavy_atom(hydrogen_flag, atomic_number, element_hydrogen);
		push_item.x      = x_coord;
		push_item.y      = y_coord;
		push_item.z      = z_coord;
		push_item.first  = first_atom;
		push_item.second = second_atom;
		push_item.order  = bond_order;
	end

endmodule

`default_nettype wire

### rtl/core/crc_queue.sv
// ----------------------------------------------------------------------------
// crc_queue
// Short queue that decouples request intake from execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire crc_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output crc_pkg::item_t      head,
	output logic                head_valid
);

	crc_pkg::item_t                   entries_q [crc_pkg::QUEUE_DEPTH];
	logic [crc_pkg::QPTR_W-1:0]       wr_q;
	logic [crc_pkg::QPTR_W-1:0]       rd_q;
	logic [crc_pkg::QCNT_W-1:0]       count_q;

	assign full       = (count_q == crc_pkg::QCNT_W'(crc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_q] <= push_item;
	end

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("request pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/core/crc_back.sv
// ----------------------------------------------------------------------------
// crc_back
// Executes queued items: ligand sums, center division, distance test,
// index remapping and bond filtering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [crc_pkg::RADIUS_W-1:0]  cfg_data,
	input  wire crc_pkg::item_t                head,
	input  wire logic                          head_valid,
	output logic                               pop,
	output logic                               done,
	output crc_pkg::result_t                   result
);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_DIVIDE    = 6'b000010,
		ST_MEASURE   = 6'b000100,
		ST_DECIDE    = 6'b001000,
		ST_BOND_READ = 6'b010000,
		ST_BOND_OUT  = 6'b100000
	} state_t;

	state_t                                    state_q;
	logic [crc_pkg::RADIUS_W-1:0]              radius_q;
	logic signed [crc_pkg::SUM_W-1:0]          sum_q [crc_pkg::AXES];
	logic [crc_pkg::HEAVY_W-1:0]               heavy_count_q;
	logic signed [crc_pkg::COORD_W-1:0]        center_q [crc_pkg::AXES];
	logic                                      center_ready_q;
	logic [crc_pkg::SEEN_W-1:0]                protein_seen_q;
	logic [crc_pkg::SEEN_W-1:0]                kept_total_q;
	logic [crc_pkg::DIVCNT_W-1:0]              div_cnt_q;
	logic [crc_pkg::AXIS_W-1:0]                axis_q;
	logic                                      done_q;

	crc_pkg::item_t                            cur_q;
	logic [crc_pkg::REM_W-1:0]                 rem_q [crc_pkg::AXES];
	logic [crc_pkg::DIV_W-1:0]                 dq_q [crc_pkg::AXES];
	logic                                      neg_q [crc_pkg::AXES];
	logic [crc_pkg::DVSR_W-1:0]                divisor_q;
	logic [crc_pkg::SQ_W-1:0]                  sq_s1;
	logic [crc_pkg::D2_W-1:0]                  d2_q;
	logic [crc_pkg::R2_W-1:0]                  r2_q;
	logic [crc_pkg::MAP_W-1:0]                 rd_first_q;
	logic [crc_pkg::MAP_W-1:0]                 rd_second_q;
	crc_pkg::result_t                          result_q;

	logic [crc_pkg::MAP_W-1:0]                 map_mem [crc_pkg::MAX_PROTEIN_ATOMS];

	logic signed [crc_pkg::COORD_W-1:0]        head_coord [crc_pkg::AXES];
	logic signed [crc_pkg::COORD_W-1:0]        cur_coord [crc_pkg::AXES];
	logic [crc_pkg::REM_W-1:0]                 trial [crc_pkg::AXES];
	logic                                      take [crc_pkg::AXES];
	logic [crc_pkg::SUM_W-1:0]                 mag [crc_pkg::AXES];
	logic signed [crc_pkg::COORD_W:0]          diff;
	logic [crc_pkg::COORD_W-1:0]               absd;
	logic [crc_pkg::D2_W-1:0]                  d2_total;
	logic                                      over;
	logic                                      keep;
	logic                                      lig_take;
	logic                                      first_ok;
	logic                                      second_ok;
	logic                                      bond_keep;
	logic                                      map_we;
	logic [crc_pkg::MAP_W-1:0]                 map_wdata;

	assign pop = (state_q == ST_IDLE) && head_valid;

	always_comb begin
		head_coord[0] = head.x;
		head_coord[1] = head.y;
		head_coord[2] = head.z;
		cur_coord[0]  = cur_q.x;
		cur_coord[1]  = cur_q.y;
		cur_coord[2]  = cur_q.z;
		for (int i = 0; i < crc_pkg::AXES; i++) begin
			trial[i] = {rem_q[i][crc_pkg::REM_W-2:0], dq_q[i][crc_pkg::DIV_W-1]};
			take[i]  = trial[i] >= crc_pkg::REM_W'(divisor_q);
			mag[i]   = sum_q[i][crc_pkg::SUM_W-1] ? crc_pkg::SUM_W'(-sum_q[i])
				: crc_pkg::SUM_W'(sum_q[i]);
		end
	end

	// Distance along the axis under measurement
	always_comb begin
		diff = (crc_pkg::COORD_W+1)'(cur_coord[axis_q]) - (crc_pkg::COORD_W+1)'(center_q[axis_q]);
		absd = diff[crc_pkg::COORD_W] ? crc_pkg::COORD_W'(-diff) : crc_pkg::COORD_W'(diff);
	end

	always_comb begin
		lig_take  = !center_ready_q && head.heavy &&
			(heavy_count_q < crc_pkg::HEAVY_W'(crc_pkg::MAX_LIGAND_ATOMS));
		d2_total  = d2_q + crc_pkg::D2_W'(sq_s1);
		over      = (protein_seen_q == crc_pkg::SEEN_W'(crc_pkg::MAX_PROTEIN_ATOMS));
		keep      = !over && (radius_q != '0) && (heavy_count_q != '0) && cur_q.heavy &&
			(d2_total <= crc_pkg::D2_W'(r2_q));
		first_ok  = !cur_q.first[crc_pkg::BOND_W-1] &&
			((crc_pkg::SEEN_W+crc_pkg::BOND_W)'(cur_q.first) <
			 (crc_pkg::SEEN_W+crc_pkg::BOND_W)'(protein_seen_q));
		second_ok = !cur_q.second[crc_pkg::BOND_W-1] &&
			((crc_pkg::SEEN_W+crc_pkg::BOND_W)'(cur_q.second) <
			 (crc_pkg::SEEN_W+crc_pkg::BOND_W)'(protein_seen_q));
		bond_keep = first_ok && second_ok && rd_first_q[crc_pkg::INDEX_W] &&
			rd_second_q[crc_pkg::INDEX_W];
		map_we    = (state_q == ST_DECIDE) && !over;
		map_wdata = keep ? {1'b1, kept_total_q[crc_pkg::INDEX_W-1:0]} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			radius_q       <= crc_pkg::RADIUS_W'(2560);
			heavy_count_q  <= '0;
			center_ready_q <= 1'b0;
			protein_seen_q <= '0;
			kept_total_q   <= '0;
			div_cnt_q      <= '0;
			axis_q         <= '0;
			done_q         <= 1'b0;
			for (int i = 0; i < crc_pkg::AXES; i++) begin
				sum_q[i]    <= '0;
				center_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we)
				radius_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					axis_q    <= '0;
					div_cnt_q <= '0;
					if (head_valid) begin
						case (head.kind)
							crc_pkg::CMD_LIGAND: begin
								if (lig_take) begin
									for (int i = 0; i < crc_pkg::AXES; i++)
										sum_q[i] <= sum_q[i] + crc_pkg::SUM_W'(head_coord[i]);
									heavy_count_q <= heavy_count_q + 1'b1;
								end
							end
							crc_pkg::CMD_PROTEIN: begin
								// Close the ligand phase on the first protein atom
								if (!center_ready_q) begin
									center_ready_q <= 1'b1;
									state_q <= (heavy_count_q != '0) ? ST_DIVIDE : ST_MEASURE;
								end else begin
									state_q <= ST_MEASURE;
								end
							end
							crc_pkg::CMD_BOND: begin
								state_q <= ST_BOND_READ;
							end
							crc_pkg::CMD_CLEAR: begin
								heavy_count_q  <= '0;
								center_ready_q <= 1'b0;
								protein_seen_q <= '0;
								kept_total_q   <= '0;
								for (int i = 0; i < crc_pkg::AXES; i++) begin
									sum_q[i]    <= '0;
									center_q[i] <= '0;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIVIDE: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == crc_pkg::DIVCNT_W'(crc_pkg::DIV_W)) begin
						for (int i = 0; i < crc_pkg::AXES; i++)
							center_q[i] <= neg_q[i] ? -dq_q[i][crc_pkg::COORD_W-1:0]
								: dq_q[i][crc_pkg::COORD_W-1:0];
						state_q <= ST_MEASURE;
					end
				end
				ST_MEASURE: begin
					axis_q <= axis_q + 1'b1;
					if (axis_q == crc_pkg::AXIS_W'(crc_pkg::AXES - 1))
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					done_q <= 1'b1;
					if (!over) begin
						protein_seen_q <= protein_seen_q + 1'b1;
						if (keep)
							kept_total_q <= kept_total_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_BOND_READ: begin
					state_q <= ST_BOND_OUT;
				end
				ST_BOND_OUT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q     <= head;
				sq_s1     <= '0;
				d2_q      <= '0;
				r2_q      <= crc_pkg::R2_W'(radius_q) * crc_pkg::R2_W'(radius_q);
				divisor_q <= {heavy_count_q, 1'b0};
				// Load rounding dividend 2|sum| + n per axis
				for (int i = 0; i < crc_pkg::AXES; i++) begin
					rem_q[i] <= '0;
					neg_q[i] <= sum_q[i][crc_pkg::SUM_W-1];
					dq_q[i]  <= {1'b0, mag[i], 1'b0} + crc_pkg::DIV_W'(heavy_count_q);
				end
			end
			ST_DIVIDE: begin
				if (div_cnt_q != crc_pkg::DIVCNT_W'(crc_pkg::DIV_W)) begin
					for (int i = 0; i < crc_pkg::AXES; i++) begin
						rem_q[i] <= take[i] ? trial[i] - crc_pkg::REM_W'(divisor_q) : trial[i];
						dq_q[i]  <= {dq_q[i][crc_pkg::DIV_W-2:0], take[i]};
					end
				end
			end
			ST_MEASURE: begin
				sq_s1 <= crc_pkg::SQ_W'(absd) * crc_pkg::SQ_W'(absd);
				d2_q  <= d2_total;
			end
			ST_DECIDE: begin
				result_q.kind       <= crc_pkg::KIND_ATOM;
				result_q.kept       <= keep;
				result_q.new_first  <= keep ? kept_total_q[crc_pkg::INDEX_W-1:0] : '0;
				result_q.new_second <= '0;
				result_q.order      <= '0;
				result_q.overflow   <= over;
			end
			ST_BOND_OUT: begin
				result_q.kind       <= crc_pkg::KIND_BOND;
				result_q.kept       <= bond_keep;
				result_q.new_first  <= bond_keep ? rd_first_q[crc_pkg::INDEX_W-1:0] : '0;
				result_q.new_second <= bond_keep ? rd_second_q[crc_pkg::INDEX_W-1:0] : '0;
				result_q.order      <= bond_keep ? cur_q.order : '0;
				result_q.overflow   <= 1'b0;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[protein_seen_q[crc_pkg::PROT_AW-1:0]] <= map_wdata;
		rd_first_q  <= map_mem[cur_q.first[crc_pkg::PROT_AW-1:0]];
		rd_second_q <= map_mem[cur_q.second[crc_pkg::PROT_AW-1:0]];
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTH
	a_kept_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		kept_total_q <= protein_seen_q) else $error("kept count passed seen count");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held two cycles");
	a_kept_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.kept && result_q.overflow))
		else $error("result both kept and overflowed");
	a_bond_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (result_q.kind == crc_pkg::KIND_BOND)) |-> !result_q.overflow)
		else $error("bond verdict carries overflow");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// Drives ligand atoms, protein atoms, bonds and job clears into the centroid
// radius crop. A table of directed requests opens the run; randomized jobs
// follow. A predictor keeps its own center, index map and radius and checks
// every strobed verdict in order.
// ----------------------------------------------------------------------------

module testbench;
	import crc_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int TOTAL_ITEMS   = 700;
	localparam int MAX_REPORTS   = 40;
	localparam int COORD_MAX     = 8388607;
	localparam int COORD_MIN     = -8388608;

	typedef struct {
		cmd_t                      cmd;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      hf;
		logic [ANUM_W-1:0]         an;
		logic                      eh;
		logic signed [BOND_W-1:0]  a;
		logic signed [BOND_W-1:0]  b;
		logic [ORDER_W-1:0]        ord;
	} request_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} row_t;

	logic                      clk              = 1'b0;
	logic                      arst_n           = 1'b0;
	logic                      start            = 1'b0;
	logic                      cfg_we           = 1'b0;
	logic [RADIUS_W-1:0]       cfg_data         = '0;
	logic [1:0]                cmd              = '0;
	logic signed [COORD_W-1:0] x_coord          = '0;
	logic signed [COORD_W-1:0] y_coord          = '0;
	logic signed [COORD_W-1:0] z_coord          = '0;
	logic                      hydrogen_flag    = 1'b0;
	logic [ANUM_W-1:0]         atomic_number    = '0;
	logic                      element_hydrogen = 1'b0;
	logic signed [BOND_W-1:0]  first_atom       = '0;
	logic signed [BOND_W-1:0]  second_atom      = '0;
	logic [ORDER_W-1:0]        bond_order       = '0;

	logic               busy;
	logic               done;
	logic               result_kind;
	logic               kept;
	logic [INDEX_W-1:0] new_first;
	logic [INDEX_W-1:0] new_second;
	logic [ORDER_W-1:0] order_out;
	logic               overflow;

	// predictor state
	logic [RADIUS_W-1:0] radius_q = 16'd2560;
	longint              acc_x, acc_y, acc_z;
	int unsigned         heavy_n;
	longint              ctr_x, ctr_y, ctr_z;
	bit                  ctr_ready;
	int unsigned         seen_n;
	int unsigned         kept_n;
	logic [MAP_W-1:0]    index_map [MAX_PROTEIN_ATOMS];

	result_t     expected_verdicts [$];
	row_t        rows [$];
	int          errors     = 0;
	int unsigned cycles     = 0;
	bit          burst      = 1'b0;
	int          sent_items = 0;

	centroid_radius_crop u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.x_coord          (x_coord),
		.y_coord          (y_coord),
		.z_coord          (z_coord),
		.hydrogen_flag    (hydrogen_flag),
		.atomic_number    (atomic_number),
		.element_hydrogen (element_hydrogen),
		.first_atom       (first_atom),
		.second_atom      (second_atom),
		.bond_order       (bond_order),
		.done             (done),
		.result_kind      (result_kind),
		.kept             (kept),
		.new_first        (new_first),
		.new_second       (new_second),
		.order_out        (order_out),
		.overflow         (overflow)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic void clear_job();
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		heavy_n = 0;
		ctr_x = 0;
		ctr_y = 0;
		ctr_z = 0;
		ctr_ready = 1'b0;
		seen_n = 0;
		kept_n = 0;
	endfunction

	function automatic bit heavy_check(input logic hf, input logic [ANUM_W-1:0] an,
			input logic eh);
		return !(hf || an == 7'd1 || (an == 7'd0 && eh));
	endfunction

	// halves round away from zero
	function automatic longint round_center(input longint s, input int unsigned n);
		longint unsigned mag;
		longint unsigned q;
		mag = (s < 0) ? -s : s;
		q = (2 * mag + n) / (2 * longint'(n));
		return (s < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint dist_sq(input request_t r);
		longint dx, dy, dz;
		dx = longint'(r.x) - ctr_x;
		dy = longint'(r.y) - ctr_y;
		dz = longint'(r.z) - ctr_z;
		return dx * dx + dy * dy + dz * dz;
	endfunction

	function automatic bit predict_verdict(input request_t r, output result_t res);
		bit               keep;
		int               a, b;
		logic [MAP_W-1:0] ma, mb;
		res = '0;
		keep = 1'b0;
		case (r.cmd)
			CMD_CLEAR: begin
				clear_job();
				return 1'b0;
			end
			CMD_LIGAND: begin
				if (!ctr_ready && heavy_check(r.hf, r.an, r.eh) && heavy_n < MAX_LIGAND_ATOMS) begin
					acc_x += longint'(r.x);
					acc_y += longint'(r.y);
					acc_z += longint'(r.z);
					heavy_n++;
				end
				return 1'b0;
			end
			CMD_PROTEIN: begin
				res.kind = KIND_ATOM;
				if (!ctr_ready) begin
					if (heavy_n != 0) begin
						ctr_x = round_center(acc_x, heavy_n);
						ctr_y = round_center(acc_y, heavy_n);
						ctr_z = round_center(acc_z, heavy_n);
					end
					ctr_ready = 1'b1;
				end
				if (seen_n >= MAX_PROTEIN_ATOMS) begin
					res.overflow = 1'b1;
					return 1'b1;
				end
				if (radius_q != 0 && heavy_n != 0 && heavy_check(r.hf, r.an, r.eh))
					keep = dist_sq(r) <= longint'(radius_q) * longint'(radius_q);
				if (keep) begin
					index_map[seen_n] = {1'b1, kept_n[INDEX_W-1:0]};
					res.kept = 1'b1;
					res.new_first = kept_n[INDEX_W-1:0];
					kept_n++;
				end else begin
					index_map[seen_n] = '0;
				end
				seen_n++;
				return 1'b1;
			end
			default: begin
				res.kind = KIND_BOND;
				a = int'(r.a);
				b = int'(r.b);
				if (a < 0 || b < 0 || a >= int'(seen_n) || b >= int'(seen_n))
					return 1'b1;
				ma = index_map[a];
				mb = index_map[b];
				if (ma[MAP_W-1] && mb[MAP_W-1]) begin
					res.kept = 1'b1;
					res.new_first = ma[INDEX_W-1:0];
					res.new_second = mb[INDEX_W-1:0];
					res.order = r.ord;
				end
				return 1'b1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict strobed with nothing expected");
			end else begin
				want = expected_verdicts.pop_front();
				if (result_kind !== want.kind)
					report_mismatch($sformatf("result_kind %b, expected %b", result_kind, want.kind));
				if (kept !== want.kept)
					report_mismatch($sformatf("kept %b, expected %b", kept, want.kept));
				if (new_first !== want.new_first)
					report_mismatch($sformatf("new_first %0d, expected %0d", new_first,
						want.new_first));
				if (new_second !== want.new_second)
					report_mismatch($sformatf("new_second %0d, expected %0d", new_second,
						want.new_second));
				if (order_out !== want.order)
					report_mismatch($sformatf("order_out %0d, expected %0d", order_out, want.order));
				if (overflow !== want.overflow)
					report_mismatch($sformatf("overflow %b, expected %b", overflow, want.overflow));
			end
		end
	end

	// ---------------------------------------------------------------- requests

	function automatic request_t atom_req(input cmd_t c, input int x, input int y, input int z,
			input bit hf, input int an, input bit eh);
		request_t r;
		r.cmd = c;
		r.x = x[COORD_W-1:0];
		r.y = y[COORD_W-1:0];
		r.z = z[COORD_W-1:0];
		r.hf = hf;
		r.an = an[ANUM_W-1:0];
		r.eh = eh;
		r.a = '0;
		r.b = '0;
		r.ord = '0;
		return r;
	endfunction

	function automatic request_t bond_req(input int a, input int b, input int ord);
		request_t r;
		r = atom_req(CMD_BOND, 0, 0, 0, 1'b0, 0, 1'b0);
		r.a = a[BOND_W-1:0];
		r.b = b[BOND_W-1:0];
		r.ord = ord[ORDER_W-1:0];
		return r;
	endfunction

	function automatic result_t verdict(input logic kind, input logic kp, input int nf,
			input int ns, input int ord, input logic ovf);
		result_t v;
		v.kind = kind;
		v.kept = kp;
		v.new_first = nf[INDEX_W-1:0];
		v.new_second = ns[INDEX_W-1:0];
		v.order = ord[ORDER_W-1:0];
		v.overflow = ovf;
		return v;
	endfunction

	task automatic add_row(input request_t r, input bit typed, input result_t want);
		row_t w;
		w.req = r;
		w.typed = typed;
		w.want = want;
		rows.insert(rows.size(), w);
	endtask

	function automatic logic signed [BOND_W-1:0] bond_end(input int v);
		return v[BOND_W-1:0];
	endfunction

	function automatic request_t noise_request(input cmd_t c);
		request_t r;
		r.cmd = c;
		r.x = COORD_W'($urandom);
		r.y = COORD_W'($urandom);
		r.z = COORD_W'($urandom);
		r.hf = 1'($urandom);
		r.an = ANUM_W'($urandom);
		r.eh = 1'($urandom);
		r.a = bond_end(int'($urandom_range(0, 4096)) - 1);
		r.b = bond_end(int'($urandom_range(0, 4096)) - 1);
		r.ord = ORDER_W'($urandom);
		return r;
	endfunction

	function automatic request_t mark_element(input request_t r, input bit hydro);
		request_t m;
		m = r;
		if (hydro) begin
			case ($urandom_range(0, 2))
				0: begin
					m.hf = 1'b1;
				end
				1: begin
					m.hf = 1'b0;
					m.an = 7'd1;
				end
				default: begin
					m.hf = 1'b0;
					m.an = 7'd0;
					m.eh = 1'b1;
				end
			endcase
		end else begin
			m.hf = 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				m.an = 7'd0;
				m.eh = 1'b0;
			end else begin
				m.an = ANUM_W'($urandom_range(2, 127));
			end
		end
		return m;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_W'(COORD_MAX);
		if (v < COORD_MIN)
			return COORD_W'(COORD_MIN);
		return v[COORD_W-1:0];
	endfunction

	function automatic longint jitter(input longint c, input int unsigned span);
		return c + longint'($urandom_range(0, 2 * span)) - longint'(span);
	endfunction

	// mostly ends of atoms already seen, some invalid or out of range
	function automatic logic signed [BOND_W-1:0] pick_end();
		case ($urandom_range(0, 9))
			0: return bond_end(-1);
			1: return bond_end($urandom_range(0, 4095));
			2: return bond_end((seen_n > 4095) ? 4095 : seen_n);
			default: return bond_end((seen_n == 0) ? 0 : $urandom_range(0, seen_n - 1));
		endcase
	endfunction

	// ---------------------------------------------------------------- driving

	// Hold the request until busy is low at a rising edge, then predict it.
	task automatic drive_request(input request_t r, input bit typed, input result_t want);
		int      gap;
		bit      has;
		result_t res;
		gap = burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= r.cmd;
		x_coord <= r.x;
		y_coord <= r.y;
		z_coord <= r.z;
		hydrogen_flag <= r.hf;
		atomic_number <= r.an;
		element_hydrogen <= r.eh;
		first_atom <= r.a;
		second_atom <= r.b;
		bond_order <= r.ord;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sent_items++;
		has = predict_verdict(r, res);
		if (has)
			expected_verdicts.insert(expected_verdicts.size(), typed ? want : res);
	endtask

	task automatic send(input request_t r);
		drive_request(r, 1'b0, '0);
	endtask

	// Drop start, let every verdict arrive, then let trailing requests drain.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radius(input logic [RADIUS_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_q = v;
	endtask

	task automatic run_job();
		longint      cx, cy, cz;
		int unsigned span, spread;
		int          n_lig, n_prot, n_bond, i, mid;
		request_t    r;
		case ($urandom_range(0, 5))
			0: set_radius(16'd0);
			1: set_radius(16'hFFFF);
			2: set_radius(16'd2560);
			3: set_radius(RADIUS_W'($urandom));
			default: set_radius(RADIUS_W'($urandom_range(64, 6000)));
		endcase
		burst = ($urandom_range(0, 3) == 0);
		send(noise_request(CMD_CLEAR));
		cx = longint'($urandom_range(0, 16000000)) - 8000000;
		cy = longint'($urandom_range(0, 16000000)) - 8000000;
		cz = longint'($urandom_range(0, 16000000)) - 8000000;
		if ($urandom_range(0, 5) == 0)
			cx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
		span = radius_q + radius_q / 3 + 16;
		spread = $urandom_range(0, span / 4);
		n_lig = $urandom_range(0, 10);
		for (i = 0; i < n_lig; i++) begin
			r = mark_element(noise_request(CMD_LIGAND), $urandom_range(0, 3) == 0);
			r.x = clamp_coord(jitter(cx, spread));
			r.y = clamp_coord(jitter(cy, spread));
			r.z = clamp_coord(jitter(cz, spread));
			send(r);
		end
		n_prot = $urandom_range(1, 40);
		mid = ($urandom_range(0, 2) == 0) ? n_prot / 2 : -1;
		for (i = 0; i < n_prot; i++) begin
			if (i == mid)
				set_radius(RADIUS_W'($urandom));
			case ($urandom_range(0, 19))
				0: send(mark_element(noise_request(CMD_LIGAND), 1'b0));
				1: send(noise_request(CMD_BOND));
				default: begin
					r = mark_element(noise_request(CMD_PROTEIN), $urandom_range(0, 5) == 0);
					if ($urandom_range(0, 9) != 0) begin
						r.x = clamp_coord(jitter(cx, span));
						r.y = clamp_coord(jitter(cy, span));
						r.z = clamp_coord(jitter(cz, span));
					end
					send(r);
				end
			endcase
		end
		n_bond = $urandom_range(0, 30);
		for (i = 0; i < n_bond; i++) begin
			r = noise_request(CMD_BOND);
			r.a = pick_end();
			r.b = pick_end();
			send(r);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		int i;
		clear_job();

		// nothing summed yet: bond and atom both drop
		add_row(bond_req(0, 0, 3), 1'b1, verdict(KIND_BOND, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 100, 100, 100, 1'b0, 6, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_CLEAR, 0, 0, 0, 1'b0, 0, 1'b0), 1'b0, '0);
		// two heavy atoms whose means land on halves; three hydrogens skipped
		add_row(atom_req(CMD_LIGAND, 256, 512, -256, 1'b0, 6, 1'b0), 1'b0, '0);
		add_row(atom_req(CMD_LIGAND, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 6, 1'b0), 1'b0, '0);
		add_row(atom_req(CMD_LIGAND, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1, 1'b0), 1'b0, '0);
		add_row(atom_req(CMD_LIGAND, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 0, 1'b1), 1'b0, '0);
		add_row(atom_req(CMD_LIGAND, 257, 513, -257, 1'b0, 127, 1'b1), 1'b0, '0);
		// center is (257, 513, -257), radius 10.0
		add_row(atom_req(CMD_PROTEIN, 257, 513, -257, 1'b0, 6, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b1, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 2817, 513, -257, 1'b0, 7, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b1, 1, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 257, 3074, -257, 1'b0, 8, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 257, 513, -257, 1'b1, 6, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 257, 513, -257, 1'b0, 0, 1'b1), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, 257, 513, -2817, 1'b0, 0, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b1, 2, 0, 0, 1'b0));
		// ligand phase is closed now
		add_row(atom_req(CMD_LIGAND, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 6, 1'b0), 1'b0, '0);
		add_row(atom_req(CMD_PROTEIN, 257, 513, -257, 1'b0, 1, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 127, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_PROTEIN, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 6, 1'b0), 1'b1,
			verdict(KIND_ATOM, 1'b0, 0, 0, 0, 1'b0));
		add_row(bond_req(0, 1, 15), 1'b1, verdict(KIND_BOND, 1'b1, 0, 1, 15, 1'b0));
		add_row(bond_req(5, 1, 7), 1'b0, '0);
		add_row(bond_req(0, 2, 9), 1'b0, '0);
		add_row(bond_req(-1, 0, 15), 1'b1, verdict(KIND_BOND, 1'b0, 0, 0, 0, 1'b0));
		add_row(bond_req(0, 9, 4), 1'b1, verdict(KIND_BOND, 1'b0, 0, 0, 0, 1'b0));
		add_row(bond_req(4095, -1, 0), 1'b1, verdict(KIND_BOND, 1'b0, 0, 0, 0, 1'b0));
		add_row(atom_req(CMD_CLEAR, 0, 0, 0, 1'b0, 0, 1'b0), 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < rows.size(); i++)
			drive_request(rows[i].req, rows[i].typed, rows[i].want);

		while (sent_items < TOTAL_ITEMS)
			run_job();

		wait_idle();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
